// ----- src/drd_pkg.sv -----
// Shared types and constants for the dictionary run decoder.
package drd_pkg;

   // Escape byte that opens a run descriptor or a doubled literal.
   localparam logic [7:0] ESC_BYTE = 8'd254;

   // Longest dictionary entry accepted; data carries four bytes at most.
   localparam int ENTRY_BYTES = 4;
   localparam logic [7:0] LEN_CAP = (ENTRY_BYTES < 4) ? 8'(ENTRY_BYTES) : 8'd4;

   typedef enum logic [2:0] {
      KIND_LITERAL   = 3'd0,
      KIND_RUN       = 3'd1,
      KIND_BAD_LEN   = 3'd2,
      KIND_BAD_INDEX = 3'd3,
      KIND_DICT_FULL = 3'd4
   } kind_type;

   typedef struct packed {
      logic       frame_start;
      logic [7:0] in_byte;
   } req_item_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] data;
      logic [2:0]  byte_count;
      logic [7:0]  repeat_res;
   } rsp_item_type;

endpackage

// ----- src/drd_stream_if.sv -----
// Valid/ready stream channel carrying one item of a given type.
interface drd_stream_if #(
   parameter type item_type = logic
);
   logic     valid;
   logic     ready;
   item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

// ----- src/dictionary_run_decoder_core.sv -----
// Dictionary run decoder: byte stream in, literals, run descriptors and errors out.
//
//  channel | dir | payload                                   | note
//  --------+-----+-------------------------------------------+---------------------------
//  req     | in  | frame_start, in_byte                      | one encoded byte per item
//  rsp     | out | kind, data, byte_count, repeat_res        | zero or one item per byte
//
// One byte per cycle while req.ready is high: each byte takes one phase update and is decoded in the
// cycle it is accepted; a result lands in the output register the next edge.
// The dictionary is a single-port memory; the entry for a run is read when
// the index byte is taken, so the count byte finds it in a register.
// reset is synchronous, active high; the dictionary is not cleared, only
// entries written in the current frame are ever read.
// req.ready drops only while a result waits and rsp.ready is low.
module dictionary_run_decoder_core
   import drd_pkg::*;
#(
   parameter int DICT_ENTRIES = 254
) (
   input  logic          clock,
   input  logic          reset,
   drd_stream_if.sink    req,
   drd_stream_if.source  rsp
);

   // address bits into the dictionary, and width of the entry counter
   localparam int AW = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
   localparam int TW = $clog2(DICT_ENTRIES + 1);

   typedef enum logic [2:0] {
      PH_WAIT,    // nothing before the first frame start
      PH_DLEN,    // expecting an entry length byte
      PH_DBYTES,  // gathering entry bytes
      PH_BODY,    // body literals
      PH_ESC,     // after an escape byte
      PH_COUNT,   // expecting the repeat count
      PH_RAW,     // raw frame, pass everything
      PH_ERR      // drop until next frame start
   } phase_type;

   phase_type     phase_ff, phase_in;
   logic [TW-1:0] entry_total_ff, entry_total_in;
   logic [2:0]    entry_length_ff, entry_length_in;
   logic [2:0]    bytes_gathered_ff, bytes_gathered_in;
   logic [31:0]   gather_word_ff, gather_word_in;
   logic [7:0]    pending_index_ff, pending_index_in;

   logic          rsp_valid_ff;
   rsp_item_type  rsp_item_ff, rsp_item_in;
   logic          emit;

   logic [34:0]   dict_mem_ff [DICT_ENTRIES];
   logic [34:0]   entry_rd_ff;

   logic          accept;
   logic          mem_we;
   logic          mem_re;
   logic [7:0]    b;
   logic          len_go;
   logic [TW-1:0] total_base;
   logic [31:0]   word_next;
   logic [2:0]    gath_next;

   // Output register frees up as soon as the consumer takes it.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign b         = req.item.in_byte;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.item  = rsp_item_ff;

   // entry length byte: a nonzero frame opener itself, or any byte in the list
   assign len_go     = req.item.frame_start ? (b != 8'd0) : (phase_ff == PH_DLEN);
   assign total_base = req.item.frame_start ? '0 : entry_total_ff;

   assign word_next = gather_word_ff | (32'(b) << {bytes_gathered_ff[1:0], 3'b000});
   assign gath_next = bytes_gathered_ff + 3'd1;

   assign mem_we = accept && !req.item.frame_start && (phase_ff == PH_DBYTES)
                   && (gath_next >= entry_length_ff)
                   && (32'(entry_total_ff) < 32'(DICT_ENTRIES));
   assign mem_re = accept && !req.item.frame_start && (phase_ff == PH_ESC)
                   && (b != ESC_BYTE);

   always_comb begin
      phase_in          = phase_ff;
      entry_total_in    = entry_total_ff;
      entry_length_in   = entry_length_ff;
      bytes_gathered_in = bytes_gathered_ff;
      gather_word_in    = gather_word_ff;
      pending_index_in  = pending_index_ff;
      emit              = 1'b0;
      rsp_item_in       = '{kind: KIND_LITERAL, data: 32'(b), byte_count: 3'd1,
                            repeat_res: 8'd1};

      if (req.item.frame_start) begin
         entry_total_in    = '0;
         entry_length_in   = '0;
         bytes_gathered_in = '0;
         gather_word_in    = '0;
         pending_index_in  = '0;
         if (b == 8'd0) begin
            phase_in = PH_RAW;
         end
      end

      if (len_go) begin
         if (b == 8'd0) begin
            phase_in = PH_BODY;
         end else if (b > LEN_CAP) begin
            phase_in    = PH_ERR;
            emit        = 1'b1;
            rsp_item_in = '{kind: KIND_BAD_LEN, data: '0, byte_count: '0, repeat_res: '0};
         end else if (32'(total_base) >= 32'(DICT_ENTRIES)) begin
            phase_in    = PH_ERR;
            emit        = 1'b1;
            rsp_item_in = '{kind: KIND_DICT_FULL, data: '0, byte_count: '0,
                            repeat_res: '0};
         end else begin
            entry_length_in   = b[2:0];
            bytes_gathered_in = '0;
            gather_word_in    = '0;
            phase_in          = PH_DBYTES;
         end
      end else if (!req.item.frame_start) begin
         unique case (phase_ff)
            PH_DBYTES: begin
               gather_word_in    = word_next;
               bytes_gathered_in = gath_next;
               if (mem_we) begin
                  entry_total_in = entry_total_ff + TW'(1);
                  phase_in       = PH_DLEN;
               end
            end
            PH_BODY: begin
               if (b == ESC_BYTE) begin
                  phase_in = PH_ESC;
               end else begin
                  emit = 1'b1;
               end
            end
            PH_ESC: begin
               if (b == ESC_BYTE) begin
                  phase_in = PH_BODY;
                  emit     = 1'b1;
               end else if (32'(b) >= 32'(entry_total_ff)) begin
                  phase_in    = PH_ERR;
                  emit        = 1'b1;
                  rsp_item_in = '{kind: KIND_BAD_INDEX, data: '0, byte_count: '0,
                                  repeat_res: '0};
               end else begin
                  pending_index_in = b;
                  phase_in         = PH_COUNT;
               end
            end
            PH_COUNT: begin
               phase_in = PH_BODY;
               // a zero count expands to nothing
               if (b != 8'd0 && 32'(pending_index_ff) < 32'(DICT_ENTRIES)) begin
                  emit        = 1'b1;
                  rsp_item_in = '{kind: KIND_RUN, data: entry_rd_ff[31:0],
                                  byte_count: entry_rd_ff[34:32], repeat_res: b};
               end
            end
            PH_RAW: begin
               emit = 1'b1;
            end
            PH_WAIT, PH_DLEN, PH_ERR: begin
               phase_in = phase_ff;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_WAIT;
         entry_total_ff    <= '0;
         entry_length_ff   <= '0;
         bytes_gathered_ff <= '0;
         gather_word_ff    <= '0;
         pending_index_ff  <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff          <= phase_in;
            entry_total_ff    <= entry_total_in;
            entry_length_ff   <= entry_length_in;
            bytes_gathered_ff <= bytes_gathered_in;
            gather_word_ff    <= gather_word_in;
            pending_index_ff  <= pending_index_in;
            rsp_valid_ff      <= emit;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload; held while the consumer stalls
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // dictionary: written while gathering the header, read at the index byte
   always_ff @(posedge clock) begin
      if (mem_we) begin
         dict_mem_ff[entry_total_ff[AW-1:0]] <= {entry_length_ff, word_next};
      end
      if (mem_re) begin
         entry_rd_ff <= dict_mem_ff[b[AW-1:0]];
      end
   end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for dictionary_run_decoder_core: byte stream in, checked results out.
`timescale 1ns / 1ps

module tb;
   import drd_pkg::*;

   localparam int DICT_ENTRIES = 254;
   localparam int LONG_HOLD    = 200;   // receiver hold-off, in cycles
   localparam int DRAIN_LIMIT  = 10000; // cycles allowed for the last results
   localparam int MAX_PRINTS   = 40;    // mismatch lines printed before going quiet

   logic clock = 1'b0;
   logic reset;

   always #1 clock = ~clock;

   drd_stream_if #(.item_type(req_item_type)) req_if ();
   drd_stream_if #(.item_type(rsp_item_type)) rsp_if ();

   dictionary_run_decoder_core #(
      .DICT_ENTRIES(DICT_ENTRIES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if)
   );

   // ---------------------------------------------------------------------
   // Decoder prediction: mirrors the byte-level decode, one byte per call.
   // ---------------------------------------------------------------------
   typedef enum logic [2:0] {
      ST_WAIT,   // no frame seen yet
      ST_LEN,    // header: next byte is an entry length or the closing zero
      ST_ENTRY,  // header: gathering entry bytes
      ST_BODY,   // body: literals and escapes
      ST_ESC,    // body: byte after an escape
      ST_COUNT,  // body: repeat count of a run
      ST_RAW,    // raw frame, all bytes pass through
      ST_ERR     // error, ignore until next frame start
   } decode_phase_type;

   decode_phase_type dec_phase   = ST_WAIT;
   logic [2:0]       dict_len  [DICT_ENTRIES];
   logic [31:0]      dict_word [DICT_ENTRIES];
   int               stored_count = 0;
   logic [2:0]       cur_len      = '0;
   logic [2:0]       got_bytes    = '0;
   logic [31:0]      cur_word     = '0;
   logic [7:0]       run_index    = '0;

   rsp_item_type expected_tokens[$];

   int  accepted_items = 0;
   int  results_seen   = 0;
   int  error_count    = 0;
   bit  send_idle      = 1'b1;
   bit  rsp_idle       = 1'b1;
   int  hold_request   = 0;   // bumped by a test to ask for one long hold-off
   int  hold_served    = 0;   // written by the receiver only

   function automatic rsp_item_type make_rsp(input kind_type k, input logic [31:0] d,
                                             input logic [2:0] c, input logic [7:0] n);
      rsp_item_type r;
      r.kind       = k;
      r.data       = d;
      r.byte_count = c;
      r.repeat_res = n;
      return r;
   endfunction

   // Header length byte: zero closes the list, else open a new entry or fail.
   function automatic bit take_length(input logic [7:0] b, output rsp_item_type r);
      if (b == 8'd0) begin
         dec_phase = ST_BODY;
         return 1'b0;
      end
      if (b > LEN_CAP) begin
         dec_phase = ST_ERR;
         r = make_rsp(KIND_BAD_LEN, '0, '0, '0);
         return 1'b1;
      end
      if (stored_count >= DICT_ENTRIES) begin
         dec_phase = ST_ERR;
         r = make_rsp(KIND_DICT_FULL, '0, '0, '0);
         return 1'b1;
      end
      cur_len   = b[2:0];
      got_bytes = '0;
      cur_word  = '0;
      dec_phase = ST_ENTRY;
      return 1'b0;
   endfunction

   // Returns 1 when the byte yields a result, with the result in r.
   function automatic bit decode_byte(input logic fs, input logic [7:0] b,
                                      output rsp_item_type r);
      if (fs) begin
         // a frame start wins over any phase; partial work is dropped
         stored_count = 0;
         cur_len      = '0;
         got_bytes    = '0;
         cur_word     = '0;
         run_index    = '0;
         if (b == 8'd0) begin
            dec_phase = ST_RAW;
            return 1'b0;
         end
         return take_length(b, r);
      end
      case (dec_phase)
         ST_LEN: begin
            return take_length(b, r);
         end
         ST_ENTRY: begin
            cur_word  = cur_word | (32'(b) << (8 * got_bytes[1:0]));
            got_bytes = got_bytes + 3'd1;
            if (got_bytes >= cur_len && stored_count < DICT_ENTRIES) begin
               dict_len[stored_count]  = cur_len;
               dict_word[stored_count] = cur_word;
               stored_count++;
               dec_phase = ST_LEN;
            end
            return 1'b0;
         end
         ST_BODY: begin
            if (b == ESC_BYTE) begin
               dec_phase = ST_ESC;
               return 1'b0;
            end
            r = make_rsp(KIND_LITERAL, 32'(b), 3'd1, 8'd1);
            return 1'b1;
         end
         ST_ESC: begin
            if (b == ESC_BYTE) begin
               // doubled escape is a plain 254
               dec_phase = ST_BODY;
               r = make_rsp(KIND_LITERAL, 32'(ESC_BYTE), 3'd1, 8'd1);
               return 1'b1;
            end
            if (int'(b) >= stored_count) begin
               dec_phase = ST_ERR;
               r = make_rsp(KIND_BAD_INDEX, '0, '0, '0);
               return 1'b1;
            end
            run_index = b;
            dec_phase = ST_COUNT;
            return 1'b0;
         end
         ST_COUNT: begin
            dec_phase = ST_BODY;
            // zero repeats expand to nothing
            if (b == 8'd0 || int'(run_index) >= DICT_ENTRIES)
               return 1'b0;
            r = make_rsp(KIND_RUN, dict_word[run_index], dict_len[run_index], b);
            return 1'b1;
         end
         ST_RAW: begin
            r = make_rsp(KIND_LITERAL, 32'(b), 3'd1, 8'd1);
            return 1'b1;
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("MISMATCH @%0t: %s", $time, what);
   endtask

   // Each accepted result is held against the oldest expectation.
   always @(posedge clock) begin : result_checker
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got = rsp_if.item;
         results_seen++;
         if (expected_tokens.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d data %h count %0d rep %0d",
                                      got.kind, got.data, got.byte_count, got.repeat_res));
         end else begin
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind)
               report_mismatch($sformatf("result %0d kind %0d, want %0d",
                                         results_seen, got.kind, want.kind));
            if (got.data !== want.data)
               report_mismatch($sformatf("result %0d data %h, want %h",
                                         results_seen, got.data, want.data));
            if (got.byte_count !== want.byte_count)
               report_mismatch($sformatf("result %0d byte_count %0d, want %0d",
                                         results_seen, got.byte_count, want.byte_count));
            if (got.repeat_res !== want.repeat_res)
               report_mismatch($sformatf("result %0d repeat_res %0d, want %0d",
                                         results_seen, got.repeat_res, want.repeat_res));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stall bursts, plus a long hold-off on request.
   // ---------------------------------------------------------------------
   initial begin : receiver
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != hold_served) begin
            hold_served = hold_request;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (rsp_idle && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(0, 7)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender. valid stays high across back-to-back items and only drops
   // for an idle burst, so it never gets two assignments in one step.
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic fs, input logic [7:0] b);
      req_item_type it;
      rsp_item_type r;
      it.frame_start = fs;
      it.in_byte     = b;
      if (send_idle && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.item  <= it;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      accepted_items++;
      if (decode_byte(fs, b, r))
         expected_tokens.insert(expected_tokens.size(), r);
   endtask

   // Header entries with random bytes; the first length byte opens the frame.
   task automatic send_entries(input int n, input int max_len);
      int len;
      for (int e = 0; e < n; e++) begin
         len = $urandom_range(1, max_len);
         send_byte(e == 0, 8'(len));
         for (int k = 0; k < len; k++)
            send_byte(1'b0, 8'($urandom_range(0, 255)));
      end
   endtask

   // Mostly well-formed dictionary frame; a few frames break off early.
   task automatic send_dict_frame(input int n, input int tokens);
      int pick;
      logic [7:0] lit;
      send_entries(n, int'(LEN_CAP));
      if ($urandom_range(0, 19) == 0) begin
         send_byte(1'b0, 8'($urandom_range(5, 255)));  // oversized entry
         return;
      end
      send_byte(1'b0, 8'd0);
      for (int t = 0; t < tokens; t++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            lit = 8'($urandom_range(0, 255));
            send_byte(1'b0, lit);
            if (lit == ESC_BYTE)
               send_byte(1'b0, ESC_BYTE);
         end else if (pick < 85) begin
            send_byte(1'b0, ESC_BYTE);
            send_byte(1'b0, 8'($urandom_range(0, n - 1)));
            send_byte(1'b0, ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
         end else if (pick < 95) begin
            send_byte(1'b0, ESC_BYTE);
            send_byte(1'b0, ESC_BYTE);
         end else if (pick < 98) begin
            // index past the dictionary; 254 is skipped since it means a literal
            send_byte(1'b0, ESC_BYTE);
            send_byte(1'b0, ($urandom_range(0, 3) == 0 || n > 253) ?
                            8'd255 : 8'($urandom_range(n, 253)));
            return;
         end else begin
            send_byte(1'b0, ESC_BYTE);  // escape cut off by the next frame
            return;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed();
      // nothing decodes before the first frame start
      send_byte(1'b0, 8'h55);
      send_byte(1'b0, 8'hFF);
      // raw frame: every byte, the escape too, is a literal
      send_byte(1'b1, 8'h00);
      send_byte(1'b0, 8'h00);
      send_byte(1'b0, 8'hFF);
      send_byte(1'b0, ESC_BYTE);
      // two entries: four bytes, then one zero byte
      send_byte(1'b1, 8'd4);
      send_byte(1'b0, 8'hAA);
      send_byte(1'b0, 8'hBB);
      send_byte(1'b0, 8'hCC);
      send_byte(1'b0, 8'hDD);
      send_byte(1'b0, 8'd1);
      send_byte(1'b0, 8'h00);
      send_byte(1'b0, 8'd0);
      send_byte(1'b0, 8'h00);
      send_byte(1'b0, 8'hFF);
      send_byte(1'b0, ESC_BYTE);
      send_byte(1'b0, ESC_BYTE);
      send_byte(1'b0, ESC_BYTE);
      send_byte(1'b0, 8'd0);
      send_byte(1'b0, 8'd255);     // longest run
      send_byte(1'b0, ESC_BYTE);
      send_byte(1'b0, 8'd1);
      send_byte(1'b0, 8'd0);       // zero count, no result
      send_byte(1'b0, ESC_BYTE);
      send_byte(1'b0, 8'd5);       // unknown index
      send_byte(1'b0, 8'd7);       // ignored after the error
   endtask

   task automatic test_header_errors();
      send_byte(1'b1, 8'd5);       // oversized length right at frame start
      send_byte(1'b0, 8'd0);
      send_byte(1'b0, ESC_BYTE);
      send_byte(1'b1, 8'd255);
      send_byte(1'b1, 8'd2);
      send_byte(1'b0, 8'd11);
      send_byte(1'b0, 8'd22);
      send_byte(1'b0, 8'd255);     // oversized second entry
      send_byte(1'b1, 8'd3);
      send_byte(1'b0, 8'd1);       // entry cut short by a raw frame
      send_byte(1'b1, 8'd0);
      send_byte(1'b0, 8'd9);
      send_byte(1'b1, 8'd1);
      send_byte(1'b0, 8'h77);
      send_byte(1'b0, 8'd0);
      send_byte(1'b0, ESC_BYTE);   // escape cut by a new frame
      send_byte(1'b1, 8'd1);
      send_byte(1'b0, 8'h66);
      send_byte(1'b0, 8'd0);
      send_byte(1'b0, ESC_BYTE);
      send_byte(1'b0, 8'd0);
      send_byte(1'b0, 8'd5);
      send_byte(1'b0, ESC_BYTE);
      send_byte(1'b0, 8'd0);       // count pending when the frame restarts
      send_byte(1'b1, 8'd0);
   endtask

   task automatic test_full_dictionary();
      // every slot used, then runs from the highest index and index zero, then an index past the end
      send_entries(DICT_ENTRIES, 1);
      send_byte(1'b0, 8'd0);
      send_byte(1'b0, ESC_BYTE);
      send_byte(1'b0, 8'(DICT_ENTRIES - 1));
      send_byte(1'b0, 8'd255);
      send_byte(1'b0, ESC_BYTE);
      send_byte(1'b0, 8'd0);
      send_byte(1'b0, 8'd1);
      send_byte(1'b0, ESC_BYTE);
      send_byte(1'b0, 8'd255);
      // one entry too many
      send_entries(DICT_ENTRIES, 1);
      send_byte(1'b0, LEN_CAP);
      send_byte(1'b0, 8'd0);
   endtask

   task automatic test_backpressure();
      send_idle = 1'b0;
      rsp_idle  = 1'b0;
      hold_request++;
      // a raw frame yields a result per byte, so the input stalls fast
      send_byte(1'b1, 8'd0);
      repeat (40) send_byte(1'b0, 8'($urandom_range(0, 255)));
      send_idle = 1'b1;
      rsp_idle  = 1'b1;
   endtask

   task automatic test_random_frames();
      int start;
      int pick;
      start = accepted_items;
      while (accepted_items - start < 150) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_dict_frame(($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                         : $urandom_range(1, 12),
                            $urandom_range(8, 40));
         end else if (pick < 85) begin
            send_byte(1'b1, 8'd0);
            repeat ($urandom_range(5, 30)) send_byte(1'b0, 8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(4, 16))
               send_byte($urandom_range(0, 15) == 0, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic test_quiet_tail();
      send_idle = 1'b0;
      rsp_idle  = 1'b0;
      repeat (4) send_dict_frame($urandom_range(1, 12), $urandom_range(10, 30));
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin : run_sequence
      req_if.valid <= 1'b0;
      req_if.item  <= '0;
      reset        <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_header_errors();
      test_full_dictionary();
      test_backpressure();
      test_random_frames();
      test_quiet_tail();
      req_if.valid <= 1'b0;

      // results are registered behind their byte and may wait on stalls; allow a bounded drain
      for (int w = 0; w < DRAIN_LIMIT && expected_tokens.size() != 0; w++)
         @(posedge clock);
      if (expected_tokens.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   expected_tokens.size()));
      repeat (16) @(posedge clock);

      $display("Covered %0d bytes and %0d results: raw and dictionary frames, a full",
               accepted_items, results_seen);
      $display("dictionary, runs, escapes, decode errors, stalls; %0d mismatches.",
               error_count);
      if (error_count == 0)
         $display("dictionary_run_decoder_core verification clean");
      else
         $display("dictionary_run_decoder_core verification failed");
      $finish;
   end

   initial begin : run_timeout
      #1_000_000;
      $display("Timeout: run did not complete");
      $display("dictionary_run_decoder_core verification failed");
      $finish;
   end

endmodule
